[rtl/core/s256_pkg.sv]
// ----------------------------------------------------------------------------
// s256_pkg
// Shared types, constants and round functions for the SHA-256 hasher.
// ----------------------------------------------------------------------------
package s256_pkg;

    // source of the byte pushed into the block window
    typedef enum logic [1:0] {
        BSRC_MSG  = 2'd0,
        BSRC_PAD  = 2'd1,
        BSRC_ZERO = 2'd2,
        BSRC_LEN  = 2'd3
    } t_byte_src;

    // commands from the controller to the datapath
    typedef struct packed {
        logic      put;        // shift one byte into the block window
        t_byte_src src;        // which byte to shift in
        logic [2:0] len_idx;   // length byte index, 0 = most significant
        logic      count_en;   // count a message byte
        logic      load_vars;  // load a..h from the hash words
        logic      round;      // run one compression round
        logic [5:0] round_idx; // round number for the constant table
        logic      update;     // add a..h into the hash words
        logic      dig_load;   // move digest to output buffer, restart hash
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic out_busy;        // output buffer still holds digest words
    } t_stat;

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [5:0] LEN_START = 6'd56;
    localparam logic [5:0] LAST_POS  = 6'd63;
    localparam logic [5:0] LAST_RND  = 6'd63;
    localparam logic [2:0] LAST_WORD = 3'd7;

    // initial hash value H0..H7
    function automatic logic [31:0] init_hash(input logic [2:0] idx);
        logic [31:0] v;
        case (idx)
            3'd0:    v = 32'h6a09e667;
            3'd1:    v = 32'hbb67ae85;
            3'd2:    v = 32'h3c6ef372;
            3'd3:    v = 32'ha54ff53a;
            3'd4:    v = 32'h510e527f;
            3'd5:    v = 32'h9b05688c;
            3'd6:    v = 32'h1f83d9ab;
            default: v = 32'h5be0cd19;
        endcase
        return v;
    endfunction

    // round constants K0..K63
    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] v;
        case (idx)
            6'd0:  v = 32'h428a2f98; 6'd1:  v = 32'h71374491;
            6'd2:  v = 32'hb5c0fbcf; 6'd3:  v = 32'he9b5dba5;
            6'd4:  v = 32'h3956c25b; 6'd5:  v = 32'h59f111f1;
            6'd6:  v = 32'h923f82a4; 6'd7:  v = 32'hab1c5ed5;
            6'd8:  v = 32'hd807aa98; 6'd9:  v = 32'h12835b01;
            6'd10: v = 32'h243185be; 6'd11: v = 32'h550c7dc3;
            6'd12: v = 32'h72be5d74; 6'd13: v = 32'h80deb1fe;
            6'd14: v = 32'h9bdc06a7; 6'd15: v = 32'hc19bf174;
            6'd16: v = 32'he49b69c1; 6'd17: v = 32'hefbe4786;
            6'd18: v = 32'h0fc19dc6; 6'd19: v = 32'h240ca1cc;
            6'd20: v = 32'h2de92c6f; 6'd21: v = 32'h4a7484aa;
            6'd22: v = 32'h5cb0a9dc; 6'd23: v = 32'h76f988da;
            6'd24: v = 32'h983e5152; 6'd25: v = 32'ha831c66d;
            6'd26: v = 32'hb00327c8; 6'd27: v = 32'hbf597fc7;
            6'd28: v = 32'hc6e00bf3; 6'd29: v = 32'hd5a79147;
            6'd30: v = 32'h06ca6351; 6'd31: v = 32'h14292967;
            6'd32: v = 32'h27b70a85; 6'd33: v = 32'h2e1b2138;
            6'd34: v = 32'h4d2c6dfc; 6'd35: v = 32'h53380d13;
            6'd36: v = 32'h650a7354; 6'd37: v = 32'h766a0abb;
            6'd38: v = 32'h81c2c92e; 6'd39: v = 32'h92722c85;
            6'd40: v = 32'ha2bfe8a1; 6'd41: v = 32'ha81a664b;
            6'd42: v = 32'hc24b8b70; 6'd43: v = 32'hc76c51a3;
            6'd44: v = 32'hd192e819; 6'd45: v = 32'hd6990624;
            6'd46: v = 32'hf40e3585; 6'd47: v = 32'h106aa070;
            6'd48: v = 32'h19a4c116; 6'd49: v = 32'h1e376c08;
            6'd50: v = 32'h2748774c; 6'd51: v = 32'h34b0bcb5;
            6'd52: v = 32'h391c0cb3; 6'd53: v = 32'h4ed8aa4a;
            6'd54: v = 32'h5b9cca4f; 6'd55: v = 32'h682e6ff3;
            6'd56: v = 32'h748f82ee; 6'd57: v = 32'h78a5636f;
            6'd58: v = 32'h84c87814; 6'd59: v = 32'h8cc70208;
            6'd60: v = 32'h90befffa; 6'd61: v = 32'ha4506ceb;
            6'd62: v = 32'hbef9a3f7; 6'd63: v = 32'hc67178f2;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

endpackage

[rtl/core/sha256_message_hasher_unit.sv]
// ----------------------------------------------------------------------------
// sha256_message_hasher_unit
// SHA-256 over a byte stream; emits the eight digest words per message.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                          | tuser      | tlast
//  s_axis   | in  | [7:0] data_byte                | byte_valid | end_of_message
//  m_axis   | out | [31:0] digest_word, [34:32]    | -          | last_word
//           |     | word_index, [39:35] zero       |            |
//
//  Bytes are taken in the idle state; every 64th byte starts a compression of
//  the block on the single round unit, followed by one hash update.
//  End of message adds the padding and length bytes, one or two block
//  compressions and a move of the digest into the output buffer.
//  Synchronous active-low reset restores the initial hash and clears counters.
//  Input stalls during compression and padding; the digest drains while the
//  next message is taken, and the next digest waits until the buffer is empty.
// ----------------------------------------------------------------------------
module sha256_message_hasher_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_axis_tuser,   // [0] byte_valid
    input  logic        s_axis_tlast,   // end_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index
    output logic        m_axis_tlast    // last_word
);
    import s256_pkg::*;

    t_cmd        cmd;
    t_stat       stat;
    logic [31:0] digest_word;
    logic [2:0]  word_index;

    s256_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_byte_valid (s_axis_tuser[0]),
        .i_eom        (s_axis_tlast),
        .o_in_ready   (s_axis_tready),
        .i_stat       (stat),
        .o_cmd        (cmd)
    );

    s256_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_data_byte   (s_axis_tdata),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_digest_word (digest_word),
        .o_word_index  (word_index),
        .o_last_word   (m_axis_tlast),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready)
    );

    assign m_axis_tdata = {5'b00000, word_index, digest_word};

    // no input is taken while rounds run
    a_no_input_in_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.round |-> !s_axis_tready)
        else $error("input accepted during compression");

    // a new digest never overwrites one still draining
    a_digest_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.dig_load |-> !m_axis_tvalid)
        else $error("digest loaded over a busy output buffer");

    // digest words leave in order without gaps
    a_digest_in_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
            (m_axis_tvalid && word_index == $past(word_index) + 3'd1))
        else $error("digest words out of order");

endmodule

[rtl/core/s256_datapath.sv]
// ----------------------------------------------------------------------------
// s256_datapath
// Block window with message schedule, round unit, hash words, byte counter
// and the digest output buffer.
// ----------------------------------------------------------------------------
module s256_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [7:0]       i_data_byte,
    input  s256_pkg::t_cmd   i_cmd,
    output s256_pkg::t_stat  o_stat,
    output logic [31:0]      o_digest_word,
    output logic [2:0]       o_word_index,
    output logic             o_last_word,
    output logic             o_out_valid,
    input  logic             i_out_ready
);
    import s256_pkg::*;

    logic [31:0] r_w [0:15];    // block window, word 0 is the current W
    logic [31:0] r_v [0:7];     // working variables a..h
    logic [31:0] r_hash [0:7];
    logic [31:0] r_dig [0:7];   // digest waiting for the output side
    logic [60:0] r_msg_bytes;
    logic [2:0]  r_oidx;
    logic        r_ovalid;

    logic [63:0] len_bits;
    logic [7:0]  put_byte;
    logic [31:0] sched_new;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch;
    logic [31:0] maj;
    logic        out_beat;

    // pick the byte to shift in
    assign len_bits = {r_msg_bytes, 3'b000};
    always_comb begin
        case (i_cmd.src)
            BSRC_MSG:  put_byte = i_data_byte;
            BSRC_PAD:  put_byte = PAD_BYTE;
            BSRC_ZERO: put_byte = 8'h00;
            BSRC_LEN:  put_byte = 8'(len_bits >> {~i_cmd.len_idx, 3'b000});
            default:   put_byte = 8'h00;
        endcase
    end

    // schedule word and round sums
    assign sched_new = small_sigma1(r_w[14]) + r_w[9] + small_sigma0(r_w[1]) + r_w[0];
    assign ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign t1  = r_v[7] + big_sigma1(r_v[4]) + ch + round_k(i_cmd.round_idx) + r_w[0];
    assign t2  = big_sigma0(r_v[0]) + maj;

    // shift bytes in, or advance the schedule one word per round
    always_ff @(posedge i_clk) begin
        if (i_cmd.put) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= {r_w[i][23:0], r_w[i+1][31:24]};
            end
            r_w[15] <= {r_w[15][23:0], put_byte};
        end else if (i_cmd.round) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= sched_new;
        end
    end

    // load and run the working variables
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_vars) begin
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= r_hash[i];
            end
        end else if (i_cmd.round) begin
            r_v[0] <= t1 + t2;
            r_v[1] <= r_v[0];
            r_v[2] <= r_v[1];
            r_v[3] <= r_v[2];
            r_v[4] <= r_v[3] + t1;
            r_v[5] <= r_v[4];
            r_v[6] <= r_v[5];
            r_v[7] <= r_v[6];
        end
    end

    // hash words and message length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                r_hash[i] <= init_hash(3'(i));
            end
            r_msg_bytes <= '0;
        end else begin
            if (i_cmd.update) begin
                for (int i = 0; i < 8; i++) begin
                    r_hash[i] <= r_hash[i] + r_v[i];
                end
            end else if (i_cmd.dig_load) begin
                for (int i = 0; i < 8; i++) begin
                    r_hash[i] <= init_hash(3'(i));
                end
            end
            if (i_cmd.dig_load) begin
                r_msg_bytes <= '0;
            end else if (i_cmd.count_en) begin
                r_msg_bytes <= r_msg_bytes + 61'd1;
            end
        end
    end

    // output buffer control
    assign out_beat = r_ovalid && i_out_ready;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_oidx   <= '0;
        end else if (i_cmd.dig_load) begin
            r_ovalid <= 1'b1;
            r_oidx   <= '0;
        end else if (out_beat) begin
            r_oidx <= r_oidx + 3'd1;
            if (r_oidx == LAST_WORD) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // digest words, drained from word 0
    always_ff @(posedge i_clk) begin
        if (i_cmd.dig_load) begin
            for (int i = 0; i < 8; i++) begin
                r_dig[i] <= r_hash[i];
            end
        end else if (out_beat) begin
            for (int i = 0; i < 7; i++) begin
                r_dig[i] <= r_dig[i+1];
            end
            r_dig[7] <= r_dig[7];
        end
    end

    assign o_stat.out_busy = r_ovalid;
    assign o_out_valid     = r_ovalid;
    assign o_digest_word   = r_dig[0];
    assign o_word_index    = r_oidx;
    assign o_last_word     = (r_oidx == LAST_WORD);

endmodule

[rtl/core/s256_ctrl.sv]
// ----------------------------------------------------------------------------
// s256_ctrl
// Sequencer: takes message bytes, runs 64 rounds per block, inserts the
// padding and length bytes, and hands the digest to the output buffer.
// ----------------------------------------------------------------------------
module s256_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_byte_valid,
    input  logic             i_eom,
    output logic             o_in_ready,
    input  s256_pkg::t_stat  i_stat,
    output s256_pkg::t_cmd   o_cmd
);
    import s256_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_ROUND  = 5'b00010,
        ST_UPDATE = 5'b00100,
        ST_PAD    = 5'b01000,
        ST_DONE   = 5'b10000
    } t_state;

    t_state     r_state, n_state;
    logic [5:0] r_byte_cnt, n_byte_cnt;
    logic [5:0] r_round, n_round;
    logic       r_pad, n_pad;         // padding owed for this message
    logic       r_sent80, n_sent80;   // pad byte 0x80 already placed
    logic       r_len_ok, n_len_ok;   // the length may go in this block
    logic       r_fin, n_fin;         // last block is being compressed

    // next state and commands
    always_comb begin
        n_state    = r_state;
        n_byte_cnt = r_byte_cnt;
        n_round    = r_round;
        n_pad      = r_pad;
        n_sent80   = r_sent80;
        n_len_ok   = r_len_ok;
        n_fin      = r_fin;
        o_cmd      = '0;
        o_cmd.src  = BSRC_MSG;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_eom) begin
                        n_pad = 1'b1;
                    end
                    if (i_byte_valid) begin
                        o_cmd.put      = 1'b1;
                        o_cmd.count_en = 1'b1;
                        n_byte_cnt     = r_byte_cnt + 6'd1;
                        if (r_byte_cnt == LAST_POS) begin
                            o_cmd.load_vars = 1'b1;
                            n_round         = '0;
                            n_state         = ST_ROUND;
                        end else if (i_eom) begin
                            n_state = ST_PAD;
                        end
                    end else if (i_eom) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_ROUND: begin
                o_cmd.round     = 1'b1;
                o_cmd.round_idx = r_round;
                n_round         = r_round + 6'd1;
                if (r_round == LAST_RND) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
                if (r_fin) begin
                    n_state = ST_DONE;
                end else if (r_pad) begin
                    // padding goes on in a new block; the length may go here if the pad byte is placed
                    n_len_ok = r_sent80;
                    n_state  = ST_PAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_PAD: begin
                o_cmd.put  = 1'b1;
                n_byte_cnt = r_byte_cnt + 6'd1;
                if (!r_sent80) begin
                    o_cmd.src = BSRC_PAD;
                    n_sent80  = 1'b1;
                    n_len_ok  = (r_byte_cnt < LEN_START);
                end else if (r_len_ok && r_byte_cnt >= LEN_START) begin
                    o_cmd.src     = BSRC_LEN;
                    o_cmd.len_idx = r_byte_cnt[2:0];
                    if (r_byte_cnt == LAST_POS) begin
                        n_fin = 1'b1;
                    end
                end else begin
                    o_cmd.src = BSRC_ZERO;
                end
                if (r_byte_cnt == LAST_POS) begin
                    o_cmd.load_vars = 1'b1;
                    n_round         = '0;
                    n_state         = ST_ROUND;
                end
            end
            ST_DONE: begin
                // hold until the previous digest has drained
                if (!i_stat.out_busy) begin
                    o_cmd.dig_load = 1'b1;
                    n_pad          = 1'b0;
                    n_sent80       = 1'b0;
                    n_len_ok       = 1'b0;
                    n_fin          = 1'b0;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_byte_cnt <= '0;
            r_round    <= '0;
            r_pad      <= 1'b0;
            r_sent80   <= 1'b0;
            r_len_ok   <= 1'b0;
            r_fin      <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_byte_cnt <= n_byte_cnt;
            r_round    <= n_round;
            r_pad      <= n_pad;
            r_sent80   <= n_sent80;
            r_len_ok   <= n_len_ok;
            r_fin      <= n_fin;
        end
    end

endmodule
